// ===== sv/spi_tx_command_engine_macros.svh =====
// assertion macros shared by the spi transmit command engine
`ifndef SPI_TX_COMMAND_ENGINE_MACROS_SVH
`define SPI_TX_COMMAND_ENGINE_MACROS_SVH

// same-cycle implication, quiet during reset
`define STCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stce assertion failed");

// next-cycle implication, quiet during reset
`define STCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stce assertion failed");

`endif

// ===== sv/stce_pkg.sv =====
// shared types and constants of the spi transmit command engine
`timescale 1ns / 1ps
package stce_pkg;

  localparam int BUFFER_WORDS_DEF   = 61;
  localparam int MAX_DATA_BYTES_DEF = 1023;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENGINE_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_RATE    = 1'b1;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [6:0] ADDR_CMD    = 7'h11;
  localparam logic [6:0] ADDR_START  = 7'h13;
  localparam logic [6:0] ADDR_CLEAR  = 7'h1b;
  localparam logic [6:0] ADDR_STATUS = 7'h1c;

  localparam int STATUS_DONE_BIT = 2;
  localparam int STATUS_BUSY_BIT = 14;

  typedef struct packed {
    logic [31:0] read_data;
    logic        buf_hit;
    logic        serial_clock;
    logic        select_n;
    logic        serial_data;
  } result_t;

endpackage

// ===== sv/stce_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface stce_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [6:0]  reg_address;
  logic [31:0] write_data;

  modport source (output valid, output func, output reg_address, output write_data,
                  input ready);
  modport sink (input valid, input func, input reg_address, input write_data,
                output ready);
endinterface

interface stce_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        serial_clock;
  logic        select_n;
  logic        serial_data;

  modport source (output valid, output read_data, output serial_clock, output select_n,
                  output serial_data, input ready);
  modport sink (input valid, input read_data, input serial_clock, input select_n,
                input serial_data, output ready);
endinterface

// ===== sv/stce_buffer.sv =====
// data buffer ram: one write port, a bus read port and a word fetch port
`timescale 1ns / 1ps
module stce_buffer #(
  parameter int DEPTH = stce_pkg::BUFFER_WORDS_DEF,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          rd_en,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rd_data,
  input  logic [AW-1:0] fetch_addr,
  output logic [31:0]   fetch_data
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
    // fetch port follows a write to its own word at once
    if (we && (waddr == fetch_addr)) begin
      fetch_data <= wdata;
    end else begin
      fetch_data <= mem[fetch_addr];
    end
  end
endmodule

// ===== sv/stce_engine.sv =====
// register file and serial shifter; engine state is updated once per accepted item, the config registers on cfg_we
`timescale 1ns / 1ps
`include "spi_tx_command_engine_macros.svh"
module stce_engine #(
  parameter int BUFFER_WORDS   = stce_pkg::BUFFER_WORDS_DEF,
  parameter int MAX_DATA_BYTES = stce_pkg::MAX_DATA_BYTES_DEF,
  parameter int AW             = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  input  logic [1:0]                       func,
  input  logic [6:0]                       reg_address,
  input  logic [31:0]                      write_data,
  input  logic                             cfg_we,
  input  logic [stce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stce_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [31:0]                      fetch_word,
  output logic                             buf_we,
  output logic                             buf_rd_en,
  output logic [AW-1:0]                    buf_addr,
  output logic [AW-1:0]                    fetch_addr,
  output stce_pkg::result_t                result
);
  import stce_pkg::*;

  localparam int CAP_INT = (BUFFER_WORDS * 4 < MAX_DATA_BYTES) ?
                           BUFFER_WORDS * 4 : MAX_DATA_BYTES;
  localparam logic [9:0] SEND_CAP = 10'(CAP_INT);
  localparam logic [8:0] DEPTH    = 9'(BUFFER_WORDS);

  logic       engine_enable;
  logic [7:0] clock_rate;
  logic [7:0] command_byte, command_byte_next;
  logic [9:0] data_length, data_length_next;
  logic [7:0] clear_mask, clear_mask_next;
  logic       done, done_next;
  logic       busy, busy_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_count, bit_count_next;
  logic [9:0] byte_index, byte_index_next;
  logic [7:0] phase_count, phase_count_next;
  logic       clock_level, clock_level_next;

  logic [9:0]  send_len;
  logic        addr_in_buf;
  logic [7:0]  fetch_byte;
  logic [31:0] reg_read;

  assign addr_in_buf = reg_address[6] && ({3'b000, reg_address[5:0]} < DEPTH);
  assign buf_addr    = AW'(reg_address[5:0]);
  assign fetch_addr  = byte_index[AW+1:2];
  assign buf_we      = fire && (func == FUNC_WRITE) && addr_in_buf;
  assign buf_rd_en   = fire;
  assign send_len    = (data_length < SEND_CAP) ? data_length : SEND_CAP;

  always_comb begin
    case (byte_index[1:0])
      2'd0:    fetch_byte = fetch_word[7:0];
      2'd1:    fetch_byte = fetch_word[15:8];
      2'd2:    fetch_byte = fetch_word[23:16];
      default: fetch_byte = fetch_word[31:24];
    endcase
  end

  always_comb begin
    reg_read = '0;
    case (reg_address)
      ADDR_CMD:    reg_read = {24'd0, command_byte};
      ADDR_START:  reg_read = {20'd0, data_length, 2'b00};
      ADDR_CLEAR:  reg_read = {24'd0, clear_mask};
      ADDR_STATUS: begin
        reg_read[STATUS_DONE_BIT] = done;
        reg_read[STATUS_BUSY_BIT] = busy;
      end
      default:     reg_read = '0;
    endcase
  end

  always_comb begin
    command_byte_next = command_byte;
    data_length_next  = data_length;
    clear_mask_next   = clear_mask;
    done_next         = done;
    busy_next         = busy;
    shift_byte_next   = shift_byte;
    bit_count_next    = bit_count;
    byte_index_next   = byte_index;
    phase_count_next  = phase_count;
    clock_level_next  = clock_level;
    if (fire) begin
      case (func)
        FUNC_WRITE: begin
          if (reg_address == ADDR_CMD) begin
            if (!busy) begin
              command_byte_next = write_data[7:0];
            end
          end else if (reg_address == ADDR_START) begin
            if (!busy) begin
              data_length_next = write_data[11:2];
              if (write_data[0]) begin
                busy_next        = 1'b1;
                done_next        = 1'b0;
                shift_byte_next  = command_byte;
                bit_count_next   = '0;
                byte_index_next  = '0;
                phase_count_next = '0;
                clock_level_next = 1'b0;
              end
            end
          end else if (reg_address == ADDR_CLEAR) begin
            clear_mask_next = write_data[7:0];
            if (write_data[STATUS_DONE_BIT]) begin
              done_next = 1'b0;
            end
          end
        end
        FUNC_TICK: begin
          if (busy && engine_enable) begin
            if (phase_count < clock_rate) begin
              phase_count_next = phase_count + 8'd1;
            end else begin
              phase_count_next = '0;
              if (!clock_level) begin
                clock_level_next = 1'b1;
              end else begin
                // falling edge: move to the next bit or byte, or end the transfer
                clock_level_next = 1'b0;
                if (bit_count == 3'd7) begin
                  bit_count_next = '0;
                  if (byte_index >= send_len) begin
                    busy_next       = 1'b0;
                    done_next       = !clear_mask[STATUS_DONE_BIT];
                    shift_byte_next = '0;
                  end else begin
                    shift_byte_next = fetch_byte;
                    byte_index_next = byte_index + 10'd1;
                  end
                end else begin
                  bit_count_next  = bit_count + 3'd1;
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.buf_hit      = (func == FUNC_READ) && addr_in_buf;
    result.read_data    = ((func == FUNC_READ) && !addr_in_buf) ? reg_read : '0;
    result.serial_clock = clock_level_next;
    result.select_n     = !busy_next;
    result.serial_data  = busy_next && shift_byte_next[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_enable <= 1'b0;
      clock_rate    <= '0;
      command_byte  <= '0;
      data_length   <= '0;
      clear_mask    <= '0;
      done          <= 1'b0;
      busy          <= 1'b0;
      shift_byte    <= '0;
      bit_count     <= '0;
      byte_index    <= '0;
      phase_count   <= '0;
      clock_level   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENGINE_ENABLE: engine_enable <= cfg_data[0];
          CFG_CLOCK_RATE:    clock_rate    <= cfg_data;
          default: ;
        endcase
      end
      command_byte <= command_byte_next;
      data_length  <= data_length_next;
      clear_mask   <= clear_mask_next;
      done         <= done_next;
      busy         <= busy_next;
      shift_byte   <= shift_byte_next;
      bit_count    <= bit_count_next;
      byte_index   <= byte_index_next;
      phase_count  <= phase_count_next;
      clock_level  <= clock_level_next;
    end
  end

  `STCE_ASSERT_IMPL(a_idle_quiet, clk, rst, !busy, (clock_level == 1'b0) && (bit_count == 3'd0))
  `STCE_ASSERT_IMPL(a_done_not_busy, clk, rst, done, !busy)
  `STCE_ASSERT_IMPL(a_index_capped, clk, rst, 1'b1, byte_index <= SEND_CAP)
endmodule

// ===== sv/stce_result_pipe.sv =====
// two result registers: a working stage and the output stage
`timescale 1ns / 1ps
`include "spi_tx_command_engine_macros.svh"
module stce_result_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              fire,
  input  stce_pkg::result_t result_d,
  input  logic [31:0]       buf_data,
  stce_rsp_if.source        rsp
);
  import stce_pkg::*;

  result_t     stage;
  logic        stage_valid;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic        out_clock;
  logic        out_select_n;
  logic        out_data;
  logic        advance;

  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign req_ready = !stage_valid || advance;
  assign fire      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      stage <= result_d;
    end
    if (advance) begin
      // buffer word arrives from the ram in the cycle after the item is taken
      out_read_data <= stage.buf_hit ? buf_data : stage.read_data;
      out_clock     <= stage.serial_clock;
      out_select_n  <= stage.select_n;
      out_data      <= stage.serial_data;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_read_data;
  assign rsp.serial_clock = out_clock;
  assign rsp.select_n     = out_select_n;
  assign rsp.serial_data  = out_data;

  `STCE_ASSERT_IMPL(a_full_blocks, clk, rst, stage_valid && out_valid && !rsp.ready, !req_ready)
  `STCE_ASSERT_NEXT(a_stage_moves, clk, rst, stage_valid && !out_valid, out_valid)
  `STCE_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !rsp.ready, out_valid)
endmodule

// ===== sv/spi_tx_command_engine.sv =====
// top level of the spi transmit command engine
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    func, reg_address, write_data
//   rsp      out        valid/ready    read_data, serial_clock, select_n, serial_data
//   cfg      in         cfg_we only    cfg_index, cfg_data
//
// one item per cycle while rsp takes each result; each result is registered in
// a working stage and then in an output stage, so one more item
// is taken while a result waits on rsp
// the buffer ram read of a bus read lands in the working stage's cycle
// synchronous reset clears the engine state and the valid flags; the buffer ram
// and the data stages keep their contents
`timescale 1ns / 1ps
module spi_tx_command_engine #(
  parameter int BUFFER_WORDS   = stce_pkg::BUFFER_WORDS_DEF,
  parameter int MAX_DATA_BYTES = stce_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  stce_req_if.sink                         req,
  stce_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [stce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stce_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import stce_pkg::*;

  localparam int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;

  logic          fire;
  logic          buf_we;
  logic          buf_rd_en;
  logic [AW-1:0] buf_addr;
  logic [AW-1:0] fetch_addr;
  logic [31:0]   buf_data;
  logic [31:0]   fetch_word;
  result_t       result;

  stce_buffer #(
    .DEPTH (BUFFER_WORDS),
    .AW    (AW)
  ) u_buffer (
    .clk        (clk),
    .we         (buf_we),
    .waddr      (buf_addr),
    .wdata      (req.write_data),
    .rd_en      (buf_rd_en),
    .raddr      (buf_addr),
    .rd_data    (buf_data),
    .fetch_addr (fetch_addr),
    .fetch_data (fetch_word)
  );

  stce_engine #(
    .BUFFER_WORDS   (BUFFER_WORDS),
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .AW             (AW)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .func        (req.func),
    .reg_address (req.reg_address),
    .write_data  (req.write_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fetch_word  (fetch_word),
    .buf_we      (buf_we),
    .buf_rd_en   (buf_rd_en),
    .buf_addr    (buf_addr),
    .fetch_addr  (fetch_addr),
    .result      (result)
  );

  stce_result_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .fire      (fire),
    .result_d  (result),
    .buf_data  (buf_data),
    .rsp       (rsp)
  );
endmodule
